@@ rtl/ssf_pkg.sv @@
// shared constants and helpers for the stream substring finder
// no dependencies; imported by ssf_match and stream_substring_finder
package ssf_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int WIN_BYTES   = PATTERN_MAX - 1;
  localparam int POS_BITS    = 16;
  localparam int OUT_POS_W   = 16;
  localparam int LEN_W       = 4;
  localparam int BSM_W       = 4;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = CFG_IDX_W'(1);

  localparam logic [POS_BITS-1:0] POS_LIMIT = {POS_BITS{1'b1}};

  typedef logic [8*PATTERN_MAX-1:0] pattern_t;
  typedef logic [8*WIN_BYTES-1:0]   window_t;

  // clamp a raw length write to 1..PATTERN_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    res = raw;
    if (raw == '0) res = LEN_W'(1);
    else if (raw > LEN_W'(PATTERN_MAX)) res = LEN_W'(PATTERN_MAX);
    return res;
  endfunction

  // reported position saturates at the output field limit
  function automatic logic [OUT_POS_W-1:0] sat_pos(input logic [POS_BITS-1:0] p);
    logic [OUT_POS_W-1:0] res;
    res = OUT_POS_W'(p);
    if ((p >> OUT_POS_W) != '0) res = {OUT_POS_W{1'b1}};
    return res;
  endfunction

endpackage

@@ rtl/stream_substring_finder.sv @@
// Stream substring finder: reports every non-overlapping occurrence of a 1 to 8 byte
// pattern in a byte stream, one result per occurrence and per text end, merged if they coincide.
// Sustains one byte per cycle while the receiver takes results; a byte passes through
// an input register, one window compare and a result register. Bytes that end
// no occurrence and close no text give no result. Write configuration while idle.
// depends on ssf_pkg and ssf_match
module stream_substring_finder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  // text input
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [7:0]                    s_tdata_i,   // [7:0] text_byte
  input  logic                          s_tlast_i,   // text_end
  // results
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [15:0]                   m_tdata_o,   // [15:0] match_position
  output logic [1:0]                    m_tuser_o,   // [0] match_found, [1] none_in_text
  output logic                          m_tlast_o    // end_of_text
);
  import ssf_pkg::*;

  pattern_t         pattern_q;
  logic [LEN_W-1:0] len_q;

  logic             in_v_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;

  window_t          recent_q;
  logic [POS_BITS-1:0] idx_q;
  logic [BSM_W-1:0] bsm_q;
  logic             found_q;

  logic             out_v_q;
  logic [15:0]      out_pos_q;
  logic [1:0]       out_user_q;
  logic             out_last_q;

  logic             win_hit;
  logic             hit;
  logic             produces;
  logic             proc;
  logic [POS_BITS-1:0] pos_raw;

  assign cfg_ready_o = 1'b1;

  ssf_match u_match (
    .pattern_i (pattern_q),
    .len_i     (len_q),
    .cur_i     (in_byte_q),
    .recent_i  (recent_q),
    .hit_o     (win_hit)
  );

  // occurrence must start after the previous one ended
  assign hit      = win_hit && (({1'b0, bsm_q} + 5'd1) >= {1'b0, len_q});
  assign produces = hit || in_last_q;
  assign proc     = in_v_q && (!produces || !out_v_q || m_tready_i);
  assign s_tready_o = !in_v_q || proc;

  always_comb begin
    if (idx_q == POS_LIMIT) pos_raw = POS_LIMIT;
    else pos_raw = idx_q - POS_BITS'(len_q - LEN_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PATTERN: pattern_q <= cfg_data_i;
        REG_PAT_LEN: len_q     <= eff_len(cfg_data_i[LEN_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_tready_o) begin
      in_v_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      idx_q    <= '0;
      bsm_q    <= '0;
      found_q  <= 1'b0;
    end else if (proc) begin
      if (in_last_q) begin
        recent_q <= '0;
        idx_q    <= '0;
        bsm_q    <= '0;
        found_q  <= 1'b0;
      end else begin
        recent_q <= {recent_q[8*WIN_BYTES-9:0], in_byte_q};
        if (idx_q != POS_LIMIT) idx_q <= idx_q + POS_BITS'(1);
        if (hit) begin
          bsm_q   <= '0;
          found_q <= 1'b1;
        end else if (bsm_q != {BSM_W{1'b1}}) begin
          bsm_q <= bsm_q + BSM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (proc && produces) begin
      out_v_q <= 1'b1;
    end else if (m_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && produces) begin
      out_pos_q  <= hit ? sat_pos(pos_raw) : '0;
      out_user_q <= {in_last_q && !found_q && !hit, hit};
      out_last_q <= in_last_q;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_pos_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

  a_none_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1] |-> m_tlast_o && !m_tuser_o[0])
    else $error("none_in_text outside text end or with a match");

  a_result_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o[0] || m_tlast_o)
    else $error("result with neither match nor text end");

  a_no_pos_without_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o[0] |-> m_tdata_o == '0)
    else $error("position set without a match");

  a_clear_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> idx_q == '0 && bsm_q == '0 && !found_q)
    else $error("text state not cleared after text end");

  a_found_after_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && hit && !in_last_q |=> found_q && bsm_q == '0)
    else $error("match not recorded in text state");

endmodule

@@ rtl/ssf_match.sv @@
// parallel window compare of the current byte and recent bytes against the pattern
// depends on ssf_pkg
module ssf_match (
  input  ssf_pkg::pattern_t          pattern_i,
  input  logic [ssf_pkg::LEN_W-1:0]  len_i,
  input  logic [7:0]                 cur_i,
  input  ssf_pkg::window_t           recent_i,
  output logic                       hit_o
);
  import ssf_pkg::*;

  logic [7:0]       win   [PATTERN_MAX];
  logic [LEN_W-1:0] back  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] byte_ok;

  // win[0] is the current byte, win[d] the byte d positions earlier
  always_comb begin
    win[0] = cur_i;
    for (int d = 1; d < PATTERN_MAX; d++) begin
      win[d] = recent_i[8*(d-1) +: 8];
    end
  end

  // pattern byte j lines up with the byte len-1-j positions back
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      back[j] = len_i - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < len_i) begin
        byte_ok[j] = (pattern_i[8*j +: 8] == win[back[j][IDX_W-1:0]]);
      end else begin
        byte_ok[j] = 1'b1;
      end
    end
  end

  assign hit_o = &byte_ok;

endmodule

@@ dv/tb.sv @@
// testbench for stream_substring_finder: random and directed byte texts against
// a cycle-free predictor of the pattern search, checked item by item at the output
// depends on rtl/ssf_pkg.sv and rtl/stream_substring_finder.sv
`timescale 1ns / 1ps

module tb;
  import ssf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYC      = 16;
  localparam int HOLD_CYC       = 300;
  localparam int ITEMS_PER_CFG  = 110;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] pos;
    logic        eot;
    logic        none;
  } report_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]          cfg_data_i  = '0;
  logic                 s_tvalid_i  = 1'b0;
  logic                 s_tready_o;
  logic [7:0]           s_tdata_i   = '0;
  logic                 s_tlast_i   = 1'b0;
  logic                 m_tvalid_o;
  logic                 m_tready_i  = 1'b0;
  logic [15:0]          m_tdata_o;
  logic [1:0]           m_tuser_o;
  logic                 m_tlast_o;

  stream_substring_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  // shadow of the configuration and of the search state
  pattern_t    cfg_pat  = '0;
  logic [3:0]  cfg_len  = 4'd1;
  window_t     recent   = '0;
  logic [15:0] byte_idx = '0;
  logic [3:0]  since    = '0;
  logic        found_any = 1'b0;

  text_item_t text_q[$];
  report_t    expected_reports[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_seq  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          err_cnt   = 0;
  int          idle_cyc  = 0;
  text_item_t  next_item;
  report_t     got, want;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned active_len();
    int unsigned len;
    len = 32'(cfg_len);
    if (len == 0) len = 1;
    else if (len > PATTERN_MAX) len = PATTERN_MAX;
    return len;
  endfunction

  task automatic note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // one accepted text byte: predict its report, then advance the search state
  task automatic find_step(input logic [7:0] ch, input logic last);
    int unsigned len;
    int          j;
    logic        hit;
    logic [15:0] pos;
    report_t     rep;
    len = active_len();
    hit = (since + 1 >= len) && (cfg_pat[8*(len-1) +: 8] == ch);
    for (j = 0; j + 1 < len; j++) begin
      if (cfg_pat[8*j +: 8] != recent[8*(len-2-j) +: 8]) hit = 1'b0;
    end
    pos = '0;
    if (hit) pos = (byte_idx >= POS_LIMIT) ? POS_LIMIT : 16'(byte_idx - (len - 1));
    if (hit || last) begin
      rep.found = hit;
      rep.pos   = pos;
      rep.eot   = last;
      rep.none  = last && !found_any && !hit;
      expected_reports.push_back(rep);
    end
    if (last) begin
      recent    = '0;
      byte_idx  = '0;
      since     = '0;
      found_any = 1'b0;
    end else begin
      recent = {recent[8*WIN_BYTES-9:0], ch};
      if (byte_idx < POS_LIMIT) byte_idx++;
      if (hit) begin
        since     = '0;
        found_any = 1'b1;
      end else if (since < 4'd15) begin
        since++;
      end
    end
  endtask

  // text driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) find_step(s_tdata_i, s_tlast_i);
      if (!s_tvalid_i || s_tready_o) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = text_q.pop_front();
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= next_item.ch;
          s_tlast_i  <= next_item.last;
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got.found = m_tuser_o[0];
        got.pos   = m_tdata_o;
        got.eot   = m_tlast_o;
        got.none  = m_tuser_o[1];
        if (expected_reports.size() == 0) begin
          note_fail($sformatf("unexpected result at %0t: found %0b pos %0d eot %0b none %0b",
                              $time, got.found, got.pos, got.eot, got.none));
        end else begin
          want = expected_reports.pop_front();
          if (got.found !== want.found || got.pos !== want.pos ||
              got.eot !== want.eot || got.none !== want.none) begin
            note_fail($sformatf(
              "mismatch at %0t (exp/got): found %0b/%0b pos %0d/%0d eot %0b/%0b none %0b/%0b",
              $time, want.found, got.found, want.pos, got.pos, want.eot, got.eot,
              want.none, got.none));
          end
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL stream_substring_finder");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_PATTERN) cfg_pat = val;
    else if (idx == REG_PAT_LEN) cfg_len = val[3:0];
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || s_tvalid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic push_item(input logic [7:0] ch, input logic last);
    text_item_t it;
    it.ch   = ch;
    it.last = last;
    text_q.push_back(it);
  endtask

  // one text of n bytes: mostly whole or partial pattern copies, some noise
  task automatic push_text(input int n);
    int unsigned len;
    int          cnt, r, plen, k;
    len = active_len();
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        plen = (r < 35) ? len : $urandom_range(len, 1);
        for (k = 0; k < plen && cnt < n; k++) begin
          push_item(cfg_pat[8*k +: 8], cnt == n - 1);
          cnt++;
        end
      end else begin
        if (r < 80) push_item(cfg_pat[8*$urandom_range(len - 1) +: 8], cnt == n - 1);
        else push_item(8'($urandom_range(255)), cnt == n - 1);
        cnt++;
      end
    end
  endtask

  initial begin
    int unsigned len_plan [12];
    logic [63:0] pat_v, len_v;
    logic [7:0]  b1, b2;
    int          s, pushed, n;
    len_plan = '{8, 1, 0, 15, 3, 5, 2, 7, 4, 6, 9, 12};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: single zero byte pattern
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b1);
    wait_drained();

    // three byte pattern with overlaps, a recheck after mismatch and a pause mid text
    write_reg(REG_PATTERN, 64'hFFFF_FFFF_FF41_4241);
    write_reg(REG_PAT_LEN, 64'd3);
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    push_item(8'h41, 1'b1);
    push_item(8'h41, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(8'h42, 1'b0);
    wait_drained();
    push_item(8'h41, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h7E, 1'b1);
    push_item(8'h41, 1'b1);
    wait_drained();

    // full length pattern ending on the last byte of the text
    write_reg(REG_PATTERN, '1);
    write_reg(REG_PAT_LEN, 64'd8);
    for (int i = 0; i < 8; i++) push_item(8'hFF, i == 7);
    wait_drained();

    // random texts over three idling regimes
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 20 : (m == 1) ? 73 : 0;
      recv_idle_pct = (m == 0) ? 73 : (m == 1) ? 20 : 0;
      for (int c = 0; c < 4; c++) begin
        s = m * 4 + c;
        b1 = 8'($urandom_range(255));
        b2 = 8'($urandom_range(255));
        case ($urandom_range(2))
          0: pat_v = {$urandom, $urandom};
          1: pat_v = {8{b1}};
          default: pat_v = {4{b2, b1}};
        endcase
        if (s == 0) pat_v = '1;
        if (s == 1) pat_v = '0;
        len_v = {$urandom, $urandom};
        len_v[3:0] = 4'(len_plan[s]);
        wait_drained();
        write_reg(REG_PATTERN, pat_v);
        write_reg(REG_PAT_LEN, len_v);
        pushed = 0;
        while (pushed < ITEMS_PER_CFG) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(60, 31) : $urandom_range(30, 1);
          push_text(n);
          pushed += n;
        end
      end
    end
    wait_drained();

    // every 0x41 byte and each text end give a result while the receiver holds off, so the input stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_PATTERN, 64'h41);
    write_reg(REG_PAT_LEN, 64'd1);
    hold_seq++;
    for (int i = 0; i < 80; i++) begin
      push_item(($urandom_range(7) == 0) ? 8'h42 : 8'h41, (i % 10) == 9);
    end
    wait_drained();

    // two byte pattern over one long text
    write_reg(REG_PATTERN, 64'hA5);
    write_reg(REG_PATTERN, {56'h0, 8'h5A} | 64'hA500);
    write_reg(REG_PAT_LEN, 64'd2);
    push_text(150);
    wait_drained();

    if (expected_reports.size() != 0)
      note_fail($sformatf("%0d results never arrived", expected_reports.size()));
    if (err_cnt == 0) begin
      $display("PASS stream_substring_finder");
    end else begin
      $display("FAIL stream_substring_finder");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ssf_pkg.sv
rtl/ssf_match.sv
rtl/stream_substring_finder.sv
dv/tb.sv
